// ----- hw/rtl/pmsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID motor speed controller package
// Shared widths, constants, configuration and control types, and the
// microprogram that sequences the datapath.
// ----------------------------------------------------------------------------
package pmsc_pkg;

  localparam int CNT_W    = 17;
  localparam int SPEED_W  = 24;
  localparam int GAIN_W   = 24;
  localparam int MUL_W    = 25;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 40;
  localparam int INTEG_W  = 18;
  localparam int DUTY_W   = 18;
  localparam int LIMIT_W  = 17;
  localparam int PERIOD_W = 16;
  localparam int STEP_W   = 4;
  localparam int IDX_W    = 3;
  localparam int CFG_W    = 24;

  localparam int GAIN_SHIFT = 12;
  localparam int SPEED_MAX  = 8388607;
  localparam int SPEED_MIN  = -8388608;
  localparam int DUTY_ONE   = 65536;

  localparam logic [IDX_W-1:0] REG_SPEED_SCALE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_ENC_REVERSE    = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_P         = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_I_DT      = 3'd3;
  localparam logic [IDX_W-1:0] REG_GAIN_D_RATE    = 3'd4;
  localparam logic [IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;
  localparam logic [IDX_W-1:0] REG_PWM_PERIOD     = 3'd6;

  localparam logic [1:0] COND_NONE     = 2'd0;
  localparam logic [1:0] COND_WAIT_IN  = 2'd1;
  localparam logic [1:0] COND_WAIT_OUT = 2'd2;

  localparam logic [2:0] MUL_NONE  = 3'd0;
  localparam logic [2:0] MUL_SPEED = 3'd1;
  localparam logic [2:0] MUL_P     = 3'd2;
  localparam logic [2:0] MUL_I     = 3'd3;
  localparam logic [2:0] MUL_D     = 3'd4;
  localparam logic [2:0] MUL_PWM   = 3'd5;

  localparam logic [3:0] OP_NOP       = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_SPEED     = 4'd2;
  localparam logic [3:0] OP_ERR       = 4'd3;
  localparam logic [3:0] OP_P         = 4'd4;
  localparam logic [3:0] OP_INTEG     = 4'd5;
  localparam logic [3:0] OP_NEGD_ADDI = 4'd6;
  localparam logic [3:0] OP_SUM       = 4'd7;
  localparam logic [3:0] OP_DUTY      = 4'd8;
  localparam logic [3:0] OP_EMIT      = 4'd9;

  localparam logic [STEP_W-1:0] STEP_FETCH = 4'd0;

  typedef struct packed {
    logic [SPEED_W-1:0]  speed_scale;
    logic                encoder_reverse;
    logic [GAIN_W-1:0]   gain_p;
    logic [GAIN_W-1:0]   gain_i_dt;
    logic [GAIN_W-1:0]   gain_d_rate;
    logic [LIMIT_W-1:0]  integral_limit;
    logic [PERIOD_W-1:0] pwm_period;
  } pmsc_cfg_t;

  typedef struct packed {
    logic [1:0]        cond;
    logic [2:0]        mul_sel;
    logic [3:0]        alu_op;
    logic [STEP_W-1:0] next_step;
  } pmsc_cw_t;

  typedef struct packed {
    pmsc_cw_t cw;
    logic     go;
  } pmsc_ctrl_t;

  function automatic pmsc_cw_t pmsc_ucode(input logic [STEP_W-1:0] step);
    pmsc_cw_t cw;
    cw.cond      = COND_NONE;
    cw.mul_sel   = MUL_NONE;
    cw.alu_op    = OP_NOP;
    cw.next_step = step + 4'd1;
    case (step)
      4'd0: begin
        cw.cond   = COND_WAIT_IN;
        cw.alu_op = OP_LOAD;
      end
      4'd1: cw.mul_sel = MUL_SPEED;
      4'd2: cw.alu_op = OP_SPEED;
      4'd3: cw.alu_op = OP_ERR;
      4'd4: cw.mul_sel = MUL_P;
      4'd5: begin
        cw.alu_op  = OP_P;
        cw.mul_sel = MUL_I;
      end
      4'd6: begin
        cw.alu_op  = OP_INTEG;
        cw.mul_sel = MUL_D;
      end
      4'd7: cw.alu_op = OP_NEGD_ADDI;
      4'd8: cw.alu_op = OP_SUM;
      4'd9: cw.alu_op = OP_DUTY;
      4'd10: cw.mul_sel = MUL_PWM;
      4'd11: begin
        cw.cond      = COND_WAIT_OUT;
        cw.alu_op    = OP_EMIT;
        cw.next_step = STEP_FETCH;
      end
      default: cw.next_step = STEP_FETCH;
    endcase
    return cw;
  endfunction

endpackage

// ----- hw/rtl/pmsc_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID motor speed controller sequencer
// Step counter over the microprogram ROM, holding on a step whose wait
// condition is not yet met.
// ----------------------------------------------------------------------------
module pmsc_sequencer
  import pmsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_free,
  output pmsc_ctrl_t ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  pmsc_cw_t          cw;
  logic              go;

  always_comb begin
    cw = pmsc_ucode(step);
    case (cw.cond)
      COND_NONE:     go = 1'b1;
      COND_WAIT_IN:  go = in_valid;
      COND_WAIT_OUT: go = out_free;
      default:       go = 1'b1;
    endcase
    step_next = go ? cw.next_step : step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_FETCH;
    end else begin
      step <= step_next;
    end
  end

  assign ctrl.cw = cw;
  assign ctrl.go = go;

endmodule

// ----- hw/rtl/pmsc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID motor speed controller datapath
// Working registers, one shared signed 25 by 25 multiplier, and the add,
// clamp and shift operations selected by the control word.
// ----------------------------------------------------------------------------
module pmsc_datapath
  import pmsc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  pmsc_ctrl_t                 ctrl,
  input  pmsc_cfg_t                  cfg,
  input  logic signed [15:0]         encoder_count,
  input  logic signed [SPEED_W-1:0]  goal_speed,
  output logic signed [SPEED_W-1:0]  speed,
  output logic signed [DUTY_W-1:0]   duty,
  output logic [PERIOD_W-1:0]        compare
);

  logic signed [CNT_W-1:0]   cnt;
  logic signed [SPEED_W-1:0] goal;
  logic signed [PROD_W-1:0]  prod;
  logic signed [MUL_W-1:0]   err;
  logic signed [MUL_W-1:0]   diff;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   dterm;
  logic signed [INTEG_W-1:0] integ;
  logic signed [INTEG_W-1:0] integral_acc;
  logic signed [SPEED_W-1:0] prev_speed;

  logic signed [CNT_W-1:0]   cnt_in;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic [DUTY_W-1:0]         mag;
  logic signed [PROD_W-1:0]  prod_neg;
  logic signed [ACC_W-1:0]   isum;
  logic signed [ACC_W-1:0]   limit_pos;
  logic signed [ACC_W-1:0]   limit_neg;

  always_comb begin
    cnt_in    = {encoder_count[15], encoder_count};
    mag       = duty[DUTY_W-1] ? -duty : duty;
    prod_neg  = -prod;
    isum      = ACC_W'(integral_acc) + ACC_W'(prod >>> GAIN_SHIFT);
    limit_pos = ACC_W'($signed({1'b0, cfg.integral_limit}));
    limit_neg = -limit_pos;
    case (ctrl.cw.mul_sel)
      MUL_SPEED: begin
        mul_a = MUL_W'(cnt);
        mul_b = {1'b0, cfg.speed_scale};
      end
      MUL_P: begin
        mul_a = err;
        mul_b = {cfg.gain_p[GAIN_W-1], cfg.gain_p};
      end
      MUL_I: begin
        mul_a = err;
        mul_b = {cfg.gain_i_dt[GAIN_W-1], cfg.gain_i_dt};
      end
      MUL_D: begin
        mul_a = diff;
        mul_b = {cfg.gain_d_rate[GAIN_W-1], cfg.gain_d_rate};
      end
      MUL_PWM: begin
        mul_a = {{(MUL_W-DUTY_W){1'b0}}, mag};
        mul_b = {{(MUL_W-PERIOD_W){1'b0}}, cfg.pwm_period};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.cw.mul_sel != MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    case (ctrl.cw.alu_op)
      OP_LOAD: begin
        if (ctrl.go) begin
          cnt  <= cfg.encoder_reverse ? -cnt_in : cnt_in;
          goal <= goal_speed;
        end
      end
      OP_SPEED: begin
        if (prod > PROD_W'(SPEED_MAX)) begin
          speed <= SPEED_W'(SPEED_MAX);
        end else if (prod < PROD_W'(SPEED_MIN)) begin
          speed <= SPEED_W'(SPEED_MIN);
        end else begin
          speed <= prod[SPEED_W-1:0];
        end
      end
      OP_ERR: begin
        err  <= {goal[SPEED_W-1], goal} - {speed[SPEED_W-1], speed};
        diff <= {speed[SPEED_W-1], speed} - {prev_speed[SPEED_W-1], prev_speed};
      end
      OP_P: acc <= ACC_W'(prod >>> GAIN_SHIFT);
      OP_INTEG: begin
        if (isum > limit_pos) begin
          integ <= limit_pos[INTEG_W-1:0];
        end else if (isum < limit_neg) begin
          integ <= limit_neg[INTEG_W-1:0];
        end else begin
          integ <= isum[INTEG_W-1:0];
        end
      end
      OP_NEGD_ADDI: begin
        dterm <= ACC_W'(prod_neg >>> GAIN_SHIFT);
        acc   <= acc + ACC_W'(integ);
      end
      OP_SUM: acc <= acc + dterm;
      OP_DUTY: begin
        if (acc > ACC_W'(DUTY_ONE)) begin
          duty <= DUTY_W'(DUTY_ONE);
        end else if (acc < ACC_W'(-DUTY_ONE)) begin
          duty <= DUTY_W'(-DUTY_ONE);
        end else begin
          duty <= acc[DUTY_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
      prev_speed   <= '0;
    end else if (ctrl.cw.alu_op == OP_DUTY) begin
      integral_acc <= integ;
      prev_speed   <= speed;
    end
  end

  assign compare = prod[2*PERIOD_W-1:PERIOD_W];

endmodule

// ----- hw/rtl/pid_motor_speed_controller_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID motor speed controller
// Fixed-point PID wheel-speed loop with an anti-windup integral clamp,
// producing a direction bit and a PWM compare value per control tick.
// ----------------------------------------------------------------------------
// Each item runs through the whole microprogram from acceptance until its result
// is loaded into the output register, and a new item can be accepted in the
// cycle after that, so the block takes no new item while one is in flight, and
// the final step waits while a finished result is still stalled at the output.
// The microprogram runs five products through a single shared 25 by 25 bit
// multiplier between its add and clamp steps. The output register holds a
// finished result while the next item is being worked on; configuration
// writes are always taken and should be made while no item is in flight.
module pid_motor_speed_controller_unit
  import pmsc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [15:0]         encoder_count,
  input  logic signed [SPEED_W-1:0]  goal_speed,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       reverse_dir,
  output logic [PERIOD_W-1:0]        pwm_compare,
  output logic signed [SPEED_W-1:0]  measured_speed,
  output logic signed [DUTY_W-1:0]   duty_cycle,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  pmsc_cfg_t                 cfg;
  pmsc_ctrl_t                ctrl;
  logic                      out_free;
  logic                      emit;
  logic signed [SPEED_W-1:0] speed;
  logic signed [DUTY_W-1:0]  duty;
  logic [PERIOD_W-1:0]       compare;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = rst || (ctrl.cw.cond != COND_WAIT_IN);
  assign emit      = ctrl.go && (ctrl.cw.alu_op == OP_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_scale     <= 24'd4096;
      cfg.encoder_reverse <= 1'b0;
      cfg.gain_p          <= '0;
      cfg.gain_i_dt       <= '0;
      cfg.gain_d_rate     <= '0;
      cfg.integral_limit  <= 17'd65536;
      cfg.pwm_period      <= 16'd65535;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SPEED_SCALE:    cfg.speed_scale     <= cfg_data;
        REG_ENC_REVERSE:    cfg.encoder_reverse <= cfg_data[0];
        REG_GAIN_P:         cfg.gain_p          <= cfg_data;
        REG_GAIN_I_DT:      cfg.gain_i_dt       <= cfg_data;
        REG_GAIN_D_RATE:    cfg.gain_d_rate     <= cfg_data;
        REG_INTEGRAL_LIMIT: cfg.integral_limit  <= cfg_data[LIMIT_W-1:0];
        REG_PWM_PERIOD:     cfg.pwm_period      <= cfg_data[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pmsc_sequencer u_sequencer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  pmsc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .cfg           (cfg),
    .encoder_count (encoder_count),
    .goal_speed    (goal_speed),
    .speed         (speed),
    .duty          (duty),
    .compare       (compare)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      reverse_dir    <= duty[DUTY_W-1];
      pwm_compare    <= compare;
      measured_speed <= speed;
      duty_cycle     <= duty;
    end
  end

`ifndef SYNTHESIS
  a_one_item_in_flight: assert property (
    @(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> in_stall
  ) else $error("Input taken on two consecutive cycles.");

  a_duty_in_range: assert property (
    @(posedge clk) disable iff (rst)
    out_valid |-> (duty_cycle <= 18'sd65536 && duty_cycle >= -18'sd65536)
  ) else $error("Duty cycle outside of plus or minus one.");

  a_direction_matches: assert property (
    @(posedge clk) disable iff (rst)
    out_valid |-> (reverse_dir == duty_cycle[DUTY_W-1])
  ) else $error("Direction bit disagrees with the duty sign.");
`endif

endmodule

// ----- sim/tb_pid_motor_speed_controller_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID motor speed controller testbench
// Drives control ticks through the speed loop under a series of register
// settings and idle, stall and hold-off mixes, predicts every result from an
// in-bench model of the loop, and checks each result field by field.
// ----------------------------------------------------------------------------
module tb_pid_motor_speed_controller_unit;
  import pmsc_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic signed [15:0]        enc;
    logic signed [SPEED_W-1:0] goal;
  } tick_cmd_t;

  typedef struct packed {
    logic                      rev;
    logic [PERIOD_W-1:0]       pwm;
    logic signed [SPEED_W-1:0] speed;
    logic signed [DUTY_W-1:0]  duty;
  } tick_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [15:0]        encoder_count = '0;
  logic signed [SPEED_W-1:0] goal_speed = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      reverse_dir;
  logic [PERIOD_W-1:0]       pwm_compare;
  logic signed [SPEED_W-1:0] measured_speed;
  logic signed [DUTY_W-1:0]  duty_cycle;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [IDX_W-1:0]          cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;

  tick_cmd_t    tick_queue[$];
  tick_result_t duty_expect_q[$];
  tick_cmd_t    drive_tick;
  tick_result_t got_result;
  tick_result_t want_result;

  pmsc_cfg_t    loop_cfg = '{24'd4096, 1'b0, 24'd0, 24'd0, 24'd0, 17'd65536, 16'd65535};
  longint       integ_st = 0;
  longint       prev_speed_st = 0;

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  logic         hold_active = 1'b0;
  logic         in_taken = 1'b0;
  int           mismatches = 0;
  int           ticks_checked = 0;
  int           settings_count = 0;
  event         hold_off_ev;

  pid_motor_speed_controller_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .encoder_count (encoder_count),
    .goal_speed    (goal_speed),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .reverse_dir   (reverse_dir),
    .pwm_compare   (pwm_compare),
    .measured_speed(measured_speed),
    .duty_cycle    (duty_cycle),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic tick_result_t speed_loop_step(input tick_cmd_t t);
    longint cnt;
    longint spd;
    longint err;
    longint p_term;
    longint i_term;
    longint d_term;
    longint duty;
    longint mag;
    longint lim;
    tick_result_t r;
    cnt = t.enc;
    if (loop_cfg.encoder_reverse) cnt = -cnt;
    spd = clip(cnt * longint'(loop_cfg.speed_scale), SPEED_MIN, SPEED_MAX);
    err = longint'(t.goal) - spd;
    lim = longint'(loop_cfg.integral_limit);
    p_term = (err * longint'($signed(loop_cfg.gain_p))) >>> GAIN_SHIFT;
    i_term = integ_st + ((err * longint'($signed(loop_cfg.gain_i_dt))) >>> GAIN_SHIFT);
    i_term = clip(i_term, -lim, lim);
    d_term = (-(longint'($signed(loop_cfg.gain_d_rate)) * (spd - prev_speed_st)))
             >>> GAIN_SHIFT;
    duty = clip(p_term + i_term + d_term, -DUTY_ONE, DUTY_ONE);
    mag = (duty < 0) ? -duty : duty;
    integ_st = i_term;
    prev_speed_st = spd;
    r.rev = (duty < 0);
    r.pwm = 16'((mag * longint'(loop_cfg.pwm_period)) >>> 16);
    r.speed = spd[SPEED_W-1:0];
    r.duty = duty[DUTY_W-1:0];
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got_result = '{reverse_dir, pwm_compare, measured_speed, duty_cycle};
        ticks_checked++;
        if (duty_expect_q.size() == 0) begin
          note_mismatch("unexpected result", '0, got_result.duty);
        end else begin
          want_result = duty_expect_q.pop_front();
          if (got_result.rev !== want_result.rev)
            note_mismatch("reverse_dir", want_result.rev, got_result.rev);
          if (got_result.pwm !== want_result.pwm)
            note_mismatch("pwm_compare", want_result.pwm, got_result.pwm);
          if (got_result.speed !== want_result.speed)
            note_mismatch("measured_speed", want_result.speed, got_result.speed);
          if (got_result.duty !== want_result.duty)
            note_mismatch("duty_cycle", want_result.duty, got_result.duty);
        end
      end
      if (in_valid && !in_stall) begin
        duty_expect_q.push_back(speed_loop_step('{encoder_count, goal_speed}));
      end
    end
    in_taken <= !rst && in_valid && !in_stall;
  end

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_tick = tick_queue.pop_front();
        in_valid <= 1'b1;
        encoder_count <= drive_tick.enc;
        goal_speed <= drive_tick.goal;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !rst && (hold_active || $urandom_range(99) < recv_stall_pct);
  end

  always begin
    @(hold_off_ev);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SPEED_SCALE:    loop_cfg.speed_scale = val;
      REG_ENC_REVERSE:    loop_cfg.encoder_reverse = val[0];
      REG_GAIN_P:         loop_cfg.gain_p = val;
      REG_GAIN_I_DT:      loop_cfg.gain_i_dt = val;
      REG_GAIN_D_RATE:    loop_cfg.gain_d_rate = val;
      REG_INTEGRAL_LIMIT: loop_cfg.integral_limit = val[LIMIT_W-1:0];
      REG_PWM_PERIOD:     loop_cfg.pwm_period = val[PERIOD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input pmsc_cfg_t s);
    write_reg(REG_SPEED_SCALE, s.speed_scale);
    write_reg(REG_ENC_REVERSE, {23'd0, s.encoder_reverse});
    write_reg(REG_GAIN_P, s.gain_p);
    write_reg(REG_GAIN_I_DT, s.gain_i_dt);
    write_reg(REG_GAIN_D_RATE, s.gain_d_rate);
    write_reg(REG_INTEGRAL_LIMIT, {7'd0, s.integral_limit});
    write_reg(REG_PWM_PERIOD, {8'd0, s.pwm_period});
    write_reg(REG_UNUSED, 24'($urandom));
    settings_count++;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (tick_queue.size() != 0 || in_valid || duty_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_tick(input logic signed [15:0] enc, input logic signed [23:0] goal);
    tick_queue.push_back('{enc, goal});
  endtask

  function automatic logic [GAIN_W-1:0] rand_gain();
    if ($urandom_range(7) == 0) return 24'($urandom);
    return 24'($urandom_range(262143) - 131072);
  endfunction

  function automatic pmsc_cfg_t rand_settings();
    pmsc_cfg_t s;
    s.speed_scale = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(8192));
    s.encoder_reverse = 1'($urandom);
    s.gain_p = rand_gain();
    s.gain_i_dt = rand_gain();
    s.gain_d_rate = rand_gain();
    case ($urandom_range(9))
      0:       s.integral_limit = 17'd0;
      1:       s.integral_limit = 17'($urandom);
      default: s.integral_limit = 17'($urandom_range(65536));
    endcase
    s.pwm_period = 16'($urandom);
    return s;
  endfunction

  task automatic queue_random_ticks(input int n);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0, 1:    push_tick(16'($urandom), 24'($urandom));
        2:       push_tick($urandom_range(1) ? 16'sh8000 : 16'sh7FFF,
                           $urandom_range(1) ? 24'sh800000 : 24'sh7FFFFF);
        default: push_tick(16'($urandom_range(400) - 200),
                           24'($urandom_range(2097152) - 1048576));
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    wait (!rst);
    push_tick(16'sd100, 24'sd409600);
    push_tick(-16'sd32768, -24'sd8388608);
    push_tick(16'sd32767, 24'sd8388607);
    wait_idle();

    load_settings('{24'd4096, 1'b0, 24'd65536, 24'd6554, 24'd3277, 17'd65536, 16'd1000});
    push_tick(16'sd0, 24'sd0);
    push_tick(16'sd10, 24'sd81920);
    push_tick(-16'sd1, -24'sd4096);
    push_tick(16'sd32767, 24'sd8388607);
    push_tick(-16'sd32768, -24'sd8388608);
    push_tick(16'sd0, 24'sd8388607);
    push_tick(16'sd0, 24'sd8388607);
    wait_idle();

    load_settings('{24'hFFFFFF, 1'b1, 24'h800000, 24'h7FFFFF, 24'h800000, 17'd131071,
                    16'd65535});
    push_tick(-16'sd32768, 24'sd0);
    push_tick(16'sd32767, -24'sd8388608);
    push_tick(16'sd1, 24'sd0);
    push_tick(16'sd0, 24'sd0);
    wait_idle();

    load_settings('{24'd0, 1'b0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 17'd0, 16'd0});
    push_tick(16'sd5, 24'sd8388607);
    push_tick(-16'sd5, -24'sd8388608);
    push_tick(16'sd0, 24'sd1);
    wait_idle();

    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      load_settings(rand_settings());
      queue_random_ticks(80);
      if (ph == 4) begin
        @(posedge clk);
        -> hold_off_ev;
      end
      wait_idle();
    end

    $display("Checked %0d control ticks under %0d register settings, including a long",
             ticks_checked, settings_count);
    $display("output hold-off and mixes of input idling and output stalls.");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
